// ----- rtl/core/slt_pkg.sv -----
// ----------------------------------------------------------------------------
// slt_pkg
// shared types, widths, token kinds and keyword tables of the tokenizer
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int LINE_BITS   = 16;
    localparam int OFFSET_BITS = 24;
    localparam int LEN_BITS    = 16;
    localparam int KIND_BITS   = 5;
    localparam int KW_COUNT    = 20;
    localparam int MODE_BITS   = 3;

    // token kinds
    localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 5'd20;
    localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 5'd21;
    localparam logic [KIND_BITS-1:0] KIND_EOL     = 5'd22;
    localparam logic [KIND_BITS-1:0] KIND_EOF     = 5'd23;

    // scan modes
    localparam logic [MODE_BITS-1:0] MODE_IDLE    = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_COMMENT = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_WORD    = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_NUMBER  = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_SIGN    = 3'd4;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // keyword text, left aligned and padded with spaces to seven characters
    localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
        "push   ", "pop    ", "display", "clear  ", "swap   ",
        "assert ", "add    ", "sub    ", "mul    ", "div    ",
        "mod    ", "load   ", "store  ", "exit   ", "int8   ",
        "int16  ", "int32  ", "int64  ", "float32", "float64"
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd4, 3'd3, 3'd7, 3'd5, 3'd4, 3'd6, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd4, 3'd5, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd7, 3'd7
    };

    typedef struct packed {
        logic eof;
        logic digit;
        logic word_start;
        logic blank;
        logic semi;
        logic newline;
        logic dot;
        logic sign;
    } char_class_t;

    typedef struct packed {
        logic [7:0]  ch;
        char_class_t cls;
    } item_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [LINE_BITS-1:0]   line;
        logic [LINE_BITS-1:0]   column;
        logic [OFFSET_BITS-1:0] offset;
        logic [LEN_BITS-1:0]    length;
        logic                   last;
    } result_t;

    // keywords that still match after character c lands at position pos
    function automatic logic [KW_COUNT-1:0] kw_keep(input logic [LEN_BITS-1:0] pos,
                                                    input logic [7:0] c);
        logic [KW_COUNT-1:0] keep;
        keep = '0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            for (int i = 0; i < 7; i++)
            begin
                if (pos == LEN_BITS'(i) && 3'(i) < KW_LEN[k]
                    && KW_TEXT[k][(6-i)*8 +: 8] == c)
                begin
                    keep[k] = 1'b1;
                end
            end
        end
        return keep;
    endfunction

    // kind of a finished word: first keyword still a candidate at full length
    function automatic logic [KIND_BITS-1:0] word_kind(input logic [KW_COUNT-1:0] cand,
                                                       input logic [LEN_BITS-1:0] len);
        logic [KIND_BITS-1:0] kind;
        kind = KIND_UNKNOWN;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (cand[k] && len == LEN_BITS'(KW_LEN[k]))
            begin
                kind = KIND_BITS'(k);
            end
        end
        return kind;
    endfunction

endpackage

// ----- rtl/core/slt_front.sv -----
// ----------------------------------------------------------------------------
// slt_front
// classifies incoming text bytes and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module slt_front
    import slt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       item_valid,
    output item_t      item,
    input  logic       item_pop
);

    localparam int QDEPTH = 2;

    item_t       mem [QDEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        wr_fire, rd_fire;
    char_class_t cls;

    // byte classes
    always_comb
    begin
        cls.eof        = end_of_text || (text_byte == CH_NUL);
        cls.digit      = (text_byte >= "0") && (text_byte <= "9");
        cls.word_start = ((text_byte >= "a") && (text_byte <= "z"))
                      || ((text_byte >= "A") && (text_byte <= "Z"))
                      || (text_byte == CH_UNDER);
        cls.blank      = (text_byte == CH_SPACE) || (text_byte == CH_TAB)
                      || (text_byte == CH_CR) || (text_byte == CH_VT)
                      || (text_byte == CH_FF);
        cls.semi       = (text_byte == CH_SEMI);
        cls.newline    = (text_byte == CH_LF);
        cls.dot        = (text_byte == CH_DOT);
        cls.sign       = (text_byte == CH_PLUS) || (text_byte == CH_MINUS);
    end

    assign full       = (count_reg == 2'(QDEPTH));
    assign item_valid = (count_reg != 2'd0);
    assign item       = mem[rd_ptr_reg];
    assign wr_fire    = push && !full;
    assign rd_fire    = item_pop && item_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_fire;
        rd_ptr_next = rd_ptr_reg ^ rd_fire;
        count_next  = count_reg + {1'b0, wr_fire} - {1'b0, rd_fire};
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            mem[wr_ptr_reg] <= '{ch: text_byte, cls: cls};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/slt_back.sv -----
// ----------------------------------------------------------------------------
// slt_back
// token engine: one classified byte per cycle while the token queue has room for two, up to two tokens out
// ----------------------------------------------------------------------------
module slt_back
    import slt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  item_t      item,
    output logic       item_pop,
    input  logic       space_ok,
    output logic [1:0] wr_n,
    output result_t    wr0,
    output result_t    wr1
);

    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [LEN_BITS-1:0]    LEN_ONE  = LEN_BITS'(1);

    logic [MODE_BITS-1:0]   mode_reg, mode_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [LINE_BITS-1:0]   col_reg, col_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [LINE_BITS-1:0]   tok_line_reg, tok_line_next;
    logic [LINE_BITS-1:0]   tok_col_reg, tok_col_next;
    logic [OFFSET_BITS-1:0] tok_off_reg, tok_off_next;
    logic [LEN_BITS-1:0]    len_reg, len_next;
    logic [KW_COUNT-1:0]    cand_reg, cand_next;
    logic                   dot_seen_reg, dot_seen_next;
    logic                   prev_eol_reg, prev_eol_next;

    char_class_t            cls;
    logic                   fire, eof;
    logic                   word_cont, num_cont, sign_cont, com_cont, cont;
    logic                   closing, begin_tok, other, p2_emit, prev_mid;
    logic [LINE_BITS-1:0]   line_mv, col_mv;
    logic [OFFSET_BITS-1:0] off_mv, eol_off;
    logic [LEN_BITS-1:0]    base_len;
    logic [KW_COUNT-1:0]    base_cand;
    result_t                close_res, p2_res;

    assign cls  = item.cls;
    assign eof  = cls.eof;
    assign fire = item_valid && space_ok;
    assign item_pop = fire;

    always_comb
    begin
        // byte extends the open token or comment
        word_cont = (mode_reg == MODE_WORD) && !eof && (cls.word_start || cls.digit);
        num_cont  = (mode_reg == MODE_NUMBER) && !eof
                 && (cls.digit || (cls.dot && !dot_seen_reg));
        sign_cont = (mode_reg == MODE_SIGN) && !eof && cls.digit;
        com_cont  = (mode_reg == MODE_COMMENT) && !eof && !cls.newline;
        cont      = word_cont || num_cont || sign_cont || com_cont;
        closing   = !cont && ((mode_reg == MODE_WORD) || (mode_reg == MODE_NUMBER)
                              || (mode_reg == MODE_SIGN));
        begin_tok = !cont && !eof && (cls.word_start || cls.digit || cls.sign);
        other     = !eof && !cls.blank && !cls.semi && !cls.newline
                 && !cls.word_start && !cls.digit && !cls.sign;
        prev_mid  = closing ? 1'b0 : prev_eol_reg;
        p2_emit   = !cont && (eof || (cls.newline && !prev_mid) || other);

        // position after this byte, saturating
        if (cls.newline)
        begin
            line_mv = (line_reg == '1) ? line_reg : line_reg + LINE_ONE;
            col_mv  = LINE_ONE;
        end
        else
        begin
            line_mv = line_reg;
            col_mv  = (col_reg == '1) ? col_reg : col_reg + LINE_ONE;
        end
        off_mv  = (off_reg == '1) ? off_reg : off_reg + OFFSET_BITS'(1);
        eol_off = (off_reg == '1) ? off_reg - OFFSET_BITS'(1) : off_reg;

        // token that ends here
        close_res.kind   = (mode_reg == MODE_WORD)   ? word_kind(cand_reg, len_reg) :
                           (mode_reg == MODE_NUMBER) ? KIND_NUMBER : KIND_UNKNOWN;
        close_res.line   = tok_line_reg;
        close_res.column = tok_col_reg;
        close_res.offset = tok_off_reg;
        close_res.length = len_reg;
        close_res.last   = !p2_emit;

        // token caused by the byte itself
        p2_res.kind   = eof ? KIND_EOF : (cls.newline ? KIND_EOL : KIND_UNKNOWN);
        p2_res.line   = line_reg;
        p2_res.column = (cls.newline && !eof) ? LINE_ONE : col_reg;
        p2_res.offset = (cls.newline && !eof) ? eol_off : off_reg;
        p2_res.length = eof ? '0 : LEN_ONE;
        p2_res.last   = 1'b1;

        wr0  = closing ? close_res : p2_res;
        wr1  = p2_res;
        wr_n = fire ? ({1'b0, closing} + {1'b0, p2_emit}) : 2'd0;

        base_len  = begin_tok ? '0 : len_reg;
        base_cand = begin_tok ? '1 : cand_reg;

        mode_next     = mode_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        off_next      = off_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        tok_off_next  = tok_off_reg;
        len_next      = len_reg;
        cand_next     = cand_reg;
        dot_seen_next = dot_seen_reg;
        prev_eol_next = prev_eol_reg;

        if (fire)
        begin
            line_next = line_mv;
            col_next  = col_mv;
            off_next  = off_mv;

            if (word_cont || num_cont || sign_cont || begin_tok)
            begin
                cand_next = base_cand & kw_keep(base_len, item.ch);
                len_next  = (base_len == '1) ? base_len : base_len + LEN_ONE;
            end

            if (num_cont && cls.dot)
            begin
                dot_seen_next = 1'b1;
            end

            if (begin_tok)
            begin
                tok_line_next = line_reg;
                tok_col_next  = col_reg;
                tok_off_next  = off_reg;
                dot_seen_next = cls.dot;
            end

            if (cont)
            begin
                if (sign_cont)
                begin
                    mode_next = MODE_NUMBER;
                end
            end
            else if (cls.semi)
            begin
                mode_next = MODE_COMMENT;
            end
            else if (cls.word_start && !eof)
            begin
                mode_next = MODE_WORD;
            end
            else if (cls.digit && !eof)
            begin
                mode_next = MODE_NUMBER;
            end
            else if (cls.sign && !eof)
            begin
                mode_next = MODE_SIGN;
            end
            else
            begin
                mode_next = MODE_IDLE;
            end

            if (p2_emit)
            begin
                prev_eol_next = (p2_res.kind == KIND_EOL);
            end
            else if (closing)
            begin
                prev_eol_next = 1'b0;
            end

            // end of text returns everything to its reset value
            if (!cont && eof)
            begin
                mode_next     = MODE_IDLE;
                line_next     = LINE_ONE;
                col_next      = LINE_ONE;
                off_next      = '0;
                tok_line_next = LINE_ONE;
                tok_col_next  = LINE_ONE;
                tok_off_next  = '0;
                len_next      = '0;
                cand_next     = '1;
                dot_seen_next = 1'b0;
                prev_eol_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            line_reg     <= LINE_ONE;
            col_reg      <= LINE_ONE;
            off_reg      <= '0;
            tok_line_reg <= LINE_ONE;
            tok_col_reg  <= LINE_ONE;
            tok_off_reg  <= '0;
            len_reg      <= '0;
            cand_reg     <= '1;
            dot_seen_reg <= 1'b0;
            prev_eol_reg <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            off_reg      <= off_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            tok_off_reg  <= tok_off_next;
            len_reg      <= len_next;
            cand_reg     <= cand_next;
            dot_seen_reg <= dot_seen_next;
            prev_eol_reg <= prev_eol_next;
        end
    end

`ifndef SYNTHESIS
    // end of text leaves the engine in its reset position
    a_eof_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && eof) |=> (mode_reg == MODE_IDLE && off_reg == '0 && len_reg == '0))
        else $error("end of text did not reset the engine");
    // two end-of-line tokens never follow one another
    a_eol_collapse: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_n != 2'd0 && wr0.kind == KIND_EOL) |-> !prev_eol_reg)
        else $error("repeated end-of-line token");
    // tokens go out only while the token queue has room for two
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_n != 2'd0) |-> space_ok)
        else $error("token written without room");
`endif

endmodule

// ----- rtl/core/slt_result_fifo.sv -----
// ----------------------------------------------------------------------------
// slt_result_fifo
// four-entry token queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module slt_result_fifo
    import slt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] wr_n,
    input  result_t    wr0,
    input  result_t    wr1,
    output logic       space_ok,
    output logic       empty,
    input  logic       pop,
    output result_t    rd_data
);

    localparam int DEPTH = 4;

    result_t    mem [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       rd_fire;

    assign empty    = (count_reg == 3'd0);
    assign space_ok = (count_reg <= 3'(DEPTH - 2));
    assign rd_fire  = pop && !empty;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + wr_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, rd_fire};
        count_next  = count_reg + {1'b0, wr_n} - {2'b00, rd_fire};
    end

    always_ff @(posedge clk)
    begin
        if (wr_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= wr0;
        end
        if (wr_n == 2'd2)
        begin
            mem[wr_ptr_reg + 2'd1] <= wr1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_n != 2'd0) |-> (count_reg <= 3'(DEPTH - 2)))
        else $error("token queue written without room");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(DEPTH))
        else $error("token queue count out of range");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        rd_fire |=> (count_reg == $past(count_reg) + {1'b0, $past(wr_n)} - 3'd1))
        else $error("token queue count lost a transfer");
`endif

endmodule

// ----- rtl/core/stack_language_tokenizer.sv -----
// ----------------------------------------------------------------------------
// stack_language_tokenizer
// byte-stream tokenizer for a small stack language
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  input    | push / full         | text_byte, end_of_text
//  tokens   | empty / pop         | token_kind, start_line, start_column,
//           |                     | start_offset, lexeme_length, last_of_run
//
//  one byte per cycle in and through the token engine while it is not stalled
//  a byte's tokens reach the token ports through the byte queue and token queue
//  reset clears both queues and the scan position (line 1, column 1, offset 0)
//  the engine stalls while the token queue has fewer than two free entries
//  full rises only when the two-entry byte queue is occupied
// ----------------------------------------------------------------------------
module stack_language_tokenizer
    import slt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // byte input
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             text_byte,
    input  logic                   end_of_text,
    // token output
    output logic                   empty,
    input  logic                   pop,
    output logic [KIND_BITS-1:0]   token_kind,
    output logic [LINE_BITS-1:0]   start_line,
    output logic [LINE_BITS-1:0]   start_column,
    output logic [OFFSET_BITS-1:0] start_offset,
    output logic [LEN_BITS-1:0]    lexeme_length,
    output logic                   last_of_run
);

    // classified byte between front and engine
    logic    item_valid;
    item_t   item;
    logic    item_pop;

    // token writes from engine into the output queue
    logic       space_ok;
    logic [1:0] wr_n;
    result_t    wr0;
    result_t    wr1;
    result_t    rd_data;

    // front: byte classes and the decoupling queue
    slt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .item_valid  (item_valid),
        .item        (item),
        .item_pop    (item_pop)
    );

    // back: scan modes, positions, keyword match, token formation
    slt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .space_ok   (space_ok),
        .wr_n       (wr_n),
        .wr0        (wr0),
        .wr1        (wr1)
    );

    // output queue: a closing token and the byte's own token may land together
    slt_result_fifo u_result_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_n     (wr_n),
        .wr0      (wr0),
        .wr1      (wr1),
        .space_ok (space_ok),
        .empty    (empty),
        .pop      (pop),
        .rd_data  (rd_data)
    );

    assign token_kind    = rd_data.kind;
    assign start_line    = rd_data.line;
    assign start_column  = rd_data.column;
    assign start_offset  = rd_data.offset;
    assign lexeme_length = rd_data.length;
    assign last_of_run   = rd_data.last;

endmodule

// ----- verif/tb_stack_language_tokenizer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stack_language_tokenizer
// self-checking bench for the byte-stream tokenizer: a short table of
// directed bytes, then random program text built mostly from well-formed
// keywords, words, numbers, comments and line ends, closed by an end of text.
// every token is checked field by field against a local scanner model or a typed table row.
// ----------------------------------------------------------------------------
module tb_stack_language_tokenizer;
    import slt_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 750;
    localparam int IDLE_PERCENT  = 32;

    // ------------------------------------------------------------------------
    // dut hookup
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic [7:0]             text_byte;
    logic                   end_of_text;
    logic                   empty;
    logic                   pop;
    logic [KIND_BITS-1:0]   token_kind;
    logic [LINE_BITS-1:0]   start_line;
    logic [LINE_BITS-1:0]   start_column;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [LEN_BITS-1:0]    lexeme_length;
    logic                   last_of_run;

    stack_language_tokenizer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .text_byte     (text_byte),
        .end_of_text   (end_of_text),
        .empty         (empty),
        .pop           (pop),
        .token_kind    (token_kind),
        .start_line    (start_line),
        .start_column  (start_column),
        .start_offset  (start_offset),
        .lexeme_length (lexeme_length),
        .last_of_run   (last_of_run)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    result_t tokens_due [$];    // tokens the scanner model says are on their way
    result_t step_tokens [$];   // tokens raised by the byte being scanned
    int      mismatches;
    int      items_sent;
    int      cycles;
    bit      steady;            // when set neither side idles

    // keyword spellings in kind order, kept here independent of the design
    string kw_names [20] = '{
        "push", "pop", "display", "clear", "swap", "assert", "add", "sub",
        "mul", "div", "mod", "load", "store", "exit", "int8", "int16",
        "int32", "int64", "float32", "float64"
    };

    // ------------------------------------------------------------------------
    // scanner model
    // ------------------------------------------------------------------------
    logic [MODE_BITS-1:0]   scan_st;
    logic [LINE_BITS-1:0]   cur_line;
    logic [LINE_BITS-1:0]   cur_col;
    logic [OFFSET_BITS-1:0] cur_off;
    logic [LINE_BITS-1:0]   tok_line;
    logic [LINE_BITS-1:0]   tok_col;
    logic [OFFSET_BITS-1:0] tok_off;
    logic [LEN_BITS-1:0]    tok_len;
    logic [7:0]             word_buf [8];  // first characters of the open word
    logic                   point_seen;
    logic                   last_was_eol;

    function automatic void clear_scan();
        scan_st      = MODE_IDLE;
        cur_line     = 1;
        cur_col      = 1;
        cur_off      = 0;
        tok_line     = 1;
        tok_col      = 1;
        tok_off      = 0;
        tok_len      = 0;
        point_seen   = 1'b0;
        last_was_eol = 1'b0;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_start(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    // step the scan position past one byte, all counters saturating
    function automatic void bump(input logic [7:0] c);
        if (c == CH_LF)
        begin
            if (cur_line != '1)
                cur_line++;
            cur_col = 1;
        end
        else if (cur_col != '1)
        begin
            cur_col++;
        end
        if (cur_off != '1)
            cur_off++;
    endfunction

    function automatic void take(input logic [7:0] c);
        if (tok_len < 8)
            word_buf[tok_len[2:0]] = c;
        if (tok_len != '1)
            tok_len++;
        bump(c);
    endfunction

    function automatic void open_tok(input logic [7:0] c, input logic [MODE_BITS-1:0] mode);
        tok_line   = cur_line;
        tok_col    = cur_col;
        tok_off    = cur_off;
        tok_len    = 0;
        point_seen = (c == CH_DOT);
        scan_st    = mode;
        take(c);
    endfunction

    function automatic void stage(input logic [KIND_BITS-1:0] kind,
                                  input logic [LINE_BITS-1:0] line,
                                  input logic [LINE_BITS-1:0] col,
                                  input logic [OFFSET_BITS-1:0] off,
                                  input logic [LEN_BITS-1:0] len);
        result_t r;
        r.kind   = kind;
        r.line   = line;
        r.column = col;
        r.offset = off;
        r.length = len;
        r.last   = 1'b0;
        step_tokens.insert(step_tokens.size(), r);
        last_was_eol = (kind == KIND_EOL);
    endfunction

    // a word is a keyword only when its whole text spells one
    function automatic logic [KIND_BITS-1:0] word_code();
        bit hit;
        for (int k = 0; k < 20; k++)
        begin
            if (tok_len == LEN_BITS'(kw_names[k].len()))
            begin
                hit = 1'b1;
                for (int i = 0; i < kw_names[k].len(); i++)
                begin
                    if (word_buf[i] != kw_names[k][i])
                        hit = 1'b0;
                end
                if (hit)
                    return KIND_BITS'(k);
            end
        end
        return KIND_UNKNOWN;
    endfunction

    function automatic void close_tok(input logic [KIND_BITS-1:0] kind);
        stage(kind, tok_line, tok_col, tok_off, tok_len);
        scan_st = MODE_IDLE;
    endfunction

    // scan one accepted byte and queue the tokens it raises; a typed token
    // from the directed table stands in for the model's single token
    function automatic void predict_tokens(input logic [7:0] c, input logic eot,
                                           input bit typed, input result_t typed_tok);
        logic                 eof;
        bit                   absorbed;
        logic [LINE_BITS-1:0] nl_line;
        step_tokens.delete();
        eof      = eot || c == CH_NUL;
        absorbed = 1'b0;
        // first let the open token either swallow the byte or close
        case (scan_st)
            MODE_WORD:
            begin
                if (!eof && (is_word_start(c) || is_digit(c)))
                begin
                    take(c);
                    absorbed = 1'b1;
                end
                else
                begin
                    close_tok(word_code());
                end
            end
            MODE_NUMBER:
            begin
                if (!eof && (is_digit(c) || (c == CH_DOT && !point_seen)))
                begin
                    if (c == CH_DOT)
                        point_seen = 1'b1;
                    take(c);
                    absorbed = 1'b1;
                end
                else
                begin
                    close_tok(KIND_NUMBER);
                end
            end
            MODE_SIGN:
            begin
                // a sign followed by a digit opens a number, else stands alone
                if (!eof && is_digit(c))
                begin
                    scan_st = MODE_NUMBER;
                    take(c);
                    absorbed = 1'b1;
                end
                else
                begin
                    close_tok(KIND_UNKNOWN);
                end
            end
            MODE_COMMENT:
            begin
                if (!eof && c != CH_LF)
                begin
                    bump(c);
                    absorbed = 1'b1;
                end
                else
                begin
                    scan_st = MODE_IDLE;
                end
            end
            default:
            begin
                scan_st = MODE_IDLE;
            end
        endcase
        // then handle the byte afresh
        if (!absorbed)
        begin
            if (eof)
            begin
                stage(KIND_EOF, cur_line, cur_col, cur_off, 0);
                clear_scan();
            end
            else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF)
            begin
                bump(c);
            end
            else if (c == CH_SEMI)
            begin
                scan_st = MODE_COMMENT;
                bump(c);
            end
            else if (c == CH_LF)
            begin
                // repeated line ends collapse into one token
                nl_line = cur_line;
                bump(c);
                if (!last_was_eol)
                    stage(KIND_EOL, nl_line, 1, cur_off - 1'b1, 1);
            end
            else if (is_word_start(c))
            begin
                open_tok(c, MODE_WORD);
            end
            else if (is_digit(c))
            begin
                open_tok(c, MODE_NUMBER);
            end
            else if (c == CH_MINUS || c == CH_PLUS)
            begin
                open_tok(c, MODE_SIGN);
            end
            else
            begin
                stage(KIND_UNKNOWN, cur_line, cur_col, cur_off, 1);
                bump(c);
            end
        end
        if (typed)
        begin
            tokens_due.insert(tokens_due.size(), typed_tok);
        end
        else if (step_tokens.size() > 0)
        begin
            step_tokens[step_tokens.size() - 1].last = 1'b1;
            foreach (step_tokens[i])
                tokens_due.insert(tokens_due.size(), step_tokens[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // byte side: called at a falling edge, returns at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic eot,
                             input bit typed = 1'b0, input result_t typed_tok = '0);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push        = 1'b1;
        text_byte   = c;
        end_of_text = eot;
        @(posedge clk);
        while (full)
            @(posedge clk);
        // transfer happened at this edge
        predict_tokens(c, eot, typed, typed_tok);
        items_sent++;
        @(negedge clk);
        push = 1'b0;
    endtask

    task automatic wait_drain();
        push = 1'b0;
        while (tokens_due.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] pick_word_char();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range("a", "z"));
            1:       return 8'($urandom_range("A", "Z"));
            2:       return 8'($urandom_range("0", "9"));
            default: return CH_UNDER;
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0:       return CH_TAB;
            1:       return CH_CR;
            2:       return CH_VT;
            3:       return CH_FF;
            default: return CH_SPACE;
        endcase
    endfunction

    // keyword, now and then with one letter's case flipped or a tail added
    task automatic send_keyword();
        int k;
        int pos;
        bit flip;
        k    = $urandom_range(0, 19);
        flip = ($urandom_range(0, 5) == 0);
        pos  = $urandom_range(0, kw_names[k].len() - 1);
        for (int i = 0; i < kw_names[k].len(); i++)
            send_byte((flip && i == pos) ? kw_names[k][i] ^ 8'h20 : kw_names[k][i], 1'b0);
        if ($urandom_range(0, 7) == 0)
            send_byte(pick_word_char(), 1'b0);
    endtask

    task automatic send_number();
        int n;
        if ($urandom_range(0, 2) == 0)
            send_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS, 1'b0);
        n = $urandom_range(1, 4);
        repeat (n)
            send_byte(8'($urandom_range("0", "9")), 1'b0);
        if ($urandom_range(0, 1))
        begin
            send_byte(CH_DOT, 1'b0);
            n = $urandom_range(0, 3);
            repeat (n)
                send_byte(8'($urandom_range("0", "9")), 1'b0);
            // second dot ends the number
            if ($urandom_range(0, 5) == 0)
            begin
                send_byte(CH_DOT, 1'b0);
                send_byte(8'($urandom_range("0", "9")), 1'b0);
            end
        end
    endtask

    // one random lexical piece plus an optional separator
    task automatic send_phrase();
        int n;
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4:
                send_keyword();
            5, 6:
            begin
                n = $urandom_range(1, 6);
                send_byte($urandom_range(0, 1) ? CH_UNDER : 8'($urandom_range("a", "z")), 1'b0);
                repeat (n - 1)
                    send_byte(pick_word_char(), 1'b0);
            end
            7, 8:
                send_number();
            9:
            begin
                // comment, sometimes left open into the end of text
                send_byte(CH_SEMI, 1'b0);
                n = $urandom_range(0, 6);
                repeat (n)
                    send_byte(8'($urandom_range(1, 255)) == CH_LF ? CH_SPACE
                                                                  : 8'($urandom_range(1, 255)),
                              1'b0);
                if ($urandom_range(0, 7) == 0)
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                else
                    send_byte(CH_LF, 1'b0);
            end
            10:
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            11:
            begin
                // sign on its own, now and then followed by an end of text
                send_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS, 1'b0);
                if ($urandom_range(0, 3) == 0)
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            12:
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    send_byte(CH_LF, 1'b0);
            end
            13:
            begin
                if ($urandom_range(0, 2) == 0)
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                else
                    send_byte(8'($urandom_range(128, 255)), 1'b0);
            end
            default:
                send_byte(pick_blank(), 1'b0);
        endcase
        case ($urandom_range(0, 5))
            0:       send_byte(CH_LF, 1'b0);
            1:       ;  // pieces run into each other
            default: send_byte(pick_blank(), 1'b0);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // token side
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        pop = rst_n && (steady || $urandom_range(0, 99) >= IDLE_PERCENT);
    end

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (tokens_due.size() == 0)
            begin
                $display("%0t: token with none expected, kind %0d line %0d column %0d",
                         $time, token_kind, start_line, start_column);
                mismatches++;
            end
            else
            begin
                want = tokens_due.pop_front();
                check_field("token_kind", want.kind, token_kind);
                check_field("start_line", want.line, start_line);
                check_field("start_column", want.column, start_column);
                check_field("start_offset", want.offset, start_offset);
                check_field("lexeme_length", want.length, lexeme_length);
                check_field("last_of_run", want.last, last_of_run);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_stack_language_tokenizer failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------------
    typedef struct {
        logic [7:0] ch;
        logic       eot;
        bit         typed;
        result_t    tok;
    } stim_row_t;

    stim_row_t directed_rows [$];

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int first_random;
        bit drained;
        push        = 1'b0;
        text_byte   = '0;
        end_of_text = 1'b0;
        rst_n       = 1'b0;
        mismatches  = 0;
        items_sent  = 0;
        cycles      = 0;
        steady      = 1'b0;
        drained     = 1'b0;
        clear_scan();

        directed_rows = '{
            // odd byte right after reset: one-byte unknown at the very start
            '{8'h40, 1'b0, 1'b1, '{KIND_UNKNOWN, 16'd1, 16'd1, 24'd0, 16'd1, 1'b1}},
            // byte zero: end of file at the next position, then back to the start
            '{CH_NUL, 1'b0, 1'b1, '{KIND_EOF, 16'd1, 16'd2, 24'd1, 16'd0, 1'b1}},
            '{CH_LF, 1'b0, 1'b1, '{KIND_EOL, 16'd1, 16'd1, 24'd0, 16'd1, 1'b1}},
            // repeated line end is dropped
            '{CH_LF, 1'b0, 1'b0, '0},
            '{"p", 1'b0, 1'b0, '0}, '{"u", 1'b0, 1'b0, '0},
            '{"s", 1'b0, 1'b0, '0}, '{"h", 1'b0, 1'b0, '0},
            '{CH_SPACE, 1'b0, 1'b0, '0},
            // signed number cut by a second dot
            '{CH_MINUS, 1'b0, 1'b0, '0}, '{"1", 1'b0, 1'b0, '0},
            '{"2", 1'b0, 1'b0, '0}, '{CH_DOT, 1'b0, 1'b0, '0},
            '{"5", 1'b0, 1'b0, '0}, '{CH_DOT, 1'b0, 1'b0, '0},
            '{"3", 1'b0, 1'b0, '0}, '{CH_TAB, 1'b0, 1'b0, '0},
            // sign before a letter stands alone
            '{CH_PLUS, 1'b0, 1'b0, '0}, '{"x", 1'b0, 1'b0, '0},
            '{CH_SEMI, 1'b0, 1'b0, '0}, '{"c", 1'b0, 1'b0, '0},
            '{CH_LF, 1'b0, 1'b0, '0},
            // sign still pending when the text ends
            '{CH_PLUS, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b0, '0}
        };

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].ch, directed_rows[i].eot,
                      directed_rows[i].typed, directed_rows[i].tok);

        // random program text, with a stretch where nobody idles
        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS)
        begin
            steady = (items_sent - first_random >= 250 && items_sent - first_random < 400);
            // hold the text back once until every token is out
            if (!drained && items_sent - first_random >= 500)
            begin
                wait_drain();
                drained = 1'b1;
            end
            send_phrase();
        end
        steady = 1'b0;

        // close whatever token is still open so that every token comes out
        send_byte(CH_NUL, 1'b1);

        wait_drain();
        // tokens pass through the byte queue and the token queue after their byte; allow a little slack
        repeat (8)
            @(posedge clk);

        if (mismatches == 0 && tokens_due.size() == 0)
            $display("tb_stack_language_tokenizer passed");
        else
            $display("tb_stack_language_tokenizer failed");
        $finish;
    end

endmodule
